// ----- src/oklab_to_linear_rgb_unit_defines.svh -----
// Assertion macros shared by the OKLab to linear RGB checker.
// Depends on signals named clk and rst_n in the scope of each use.
`ifndef OKLAB_TO_LINEAR_RGB_UNIT_DEFINES_SVH
`define OKLAB_TO_LINEAR_RGB_UNIT_DEFINES_SVH

// Implication checked at every rising edge outside reset.
`define OLRGB_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("olrgb check failed");

// Condition that must hold at every rising edge outside reset.
`define OLRGB_ASSERT_ALWAYS(label, cond) \
  `OLRGB_ASSERT_IMP(label, 1'b1, cond)

`endif

// ----- src/olrgb_pkg.sv -----
// Shared widths, types and matrix coefficients for the OKLab to linear RGB unit.
// No dependencies.
`timescale 1ns / 1ps

package olrgb_pkg;

  localparam int NUM_CH      = 3;
  localparam int IN_W        = 16;
  localparam int CONE_SUM_W  = 34;  // Q.30 cone sum, full input range
  localparam int CONE_Q16_W  = 19;  // rounded cone value, Q.16
  localparam int CONE_SQ_W   = 38;  // cone value squared, Q.32
  localparam int CONE_CUBE_W = 57;  // cone value cubed, Q.48
  localparam int CONE_Q24_W  = 31;  // rounded cube, Q.24
  localparam int COEF1_W     = 18;
  localparam int COEF2_W     = 17;
  localparam int PROD_W      = 49;  // cube times second matrix coefficient, Q.38
  localparam int CHAN_SUM_W  = 50;
  localparam int OUT_W       = 15;
  localparam int ONE_Q14     = 16384;
  localparam int LATENCY     = 6;

  typedef logic signed [IN_W-1:0]       lab_t;
  typedef logic signed [CONE_SUM_W-1:0] cone_sum_t;
  typedef logic [CONE_Q16_W-1:0]        cone_q16_t;
  typedef logic [CONE_SQ_W-1:0]         cone_sq_t;
  typedef logic [CONE_CUBE_W-1:0]       cone_cube_t;
  typedef logic [CONE_Q24_W-1:0]        cone_q24_t;
  typedef logic signed [PROD_W-1:0]     prod_t;
  typedef logic signed [CHAN_SUM_W-1:0] chan_sum_t;
  typedef logic [OUT_W-1:0]             chan_t;

  // First matrix in Q.16: rows l, m, s; columns a, b. The L column is 1.0 for every row.
  localparam logic signed [COEF1_W-1:0] CONE_COEF [NUM_CH][2] = '{
    '{ 18'sd25974,  18'sd14143},
    '{-18'sd6918,  -18'sd4185},
    '{-18'sd5864,  -18'sd84639}
  };

  // Second matrix in Q.14: rows red, green, blue; columns l, m, s.
  localparam logic signed [COEF2_W-1:0] RGB_COEF [NUM_CH][NUM_CH] = '{
    '{ 17'sd64429, -17'sd52275,  17'sd3650},
    '{-17'sd20047,  17'sd42161, -17'sd5551},
    '{-17'sd66,    -17'sd11527,  17'sd27978}
  };

endpackage

// ----- src/olrgb_cone.sv -----
// First matrix, zero clamp, rounding to Q.16 and squaring of the three cone values.
// Two register stages. Depends on olrgb_pkg.
`timescale 1ns / 1ps

module olrgb_cone
  import olrgb_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  lab_t      lab_l,
  input  lab_t      lab_a,
  input  lab_t      lab_b,
  output logic      out_valid,
  output cone_q16_t cone_q16 [NUM_CH],
  output cone_sq_t  cone_sq [NUM_CH]
);

  logic      v1_r;
  logic      v2_r;
  cone_sum_t sum_nxt [NUM_CH];
  cone_sum_t sum_r [NUM_CH];
  cone_sum_t rnd [NUM_CH];
  cone_q16_t c_nxt [NUM_CH];
  cone_q16_t c_r [NUM_CH];
  cone_sq_t  sq_nxt [NUM_CH];
  cone_sq_t  sq_r [NUM_CH];

  // Stage one: L scaled to Q.30 plus the a and b products.
  always_comb begin
    for (int i = 0; i < NUM_CH; i++) begin
      sum_nxt[i] = CONE_SUM_W'($signed({lab_l, 16'h0000}))
                 + CONE_SUM_W'(lab_a) * CONE_SUM_W'(CONE_COEF[i][0])
                 + CONE_SUM_W'(lab_b) * CONE_SUM_W'(CONE_COEF[i][1]);
    end
  end

  // Stage two: clamp at zero, round to Q.16 and square.
  always_comb begin
    for (int i = 0; i < NUM_CH; i++) begin
      rnd[i] = sum_r[i] + CONE_SUM_W'(1 << 13);
      if (sum_r[i] <= 0) begin
        c_nxt[i] = '0;
      end else begin
        c_nxt[i] = rnd[i][CONE_Q16_W+13:14];
      end
      sq_nxt[i] = CONE_SQ_W'(c_nxt[i]) * CONE_SQ_W'(c_nxt[i]);
    end
  end

  // Valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
  end

  // Data registers.
  always_ff @(posedge clk) begin
    sum_r <= sum_nxt;
    c_r   <= c_nxt;
    sq_r  <= sq_nxt;
  end

  assign out_valid = v2_r;
  assign cone_q16  = c_r;
  assign cone_sq   = sq_r;

endmodule

// ----- src/olrgb_cube.sv -----
// Completes the cube of each cone value and rounds it from Q.48 to Q.24.
// Two register stages. Depends on olrgb_pkg.
`timescale 1ns / 1ps

module olrgb_cube
  import olrgb_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  cone_q16_t cone_q16 [NUM_CH],
  input  cone_sq_t  cone_sq [NUM_CH],
  output logic      out_valid,
  output cone_q24_t cone_q24 [NUM_CH]
);

  logic       v3_r;
  logic       v4_r;
  cone_cube_t cube_nxt [NUM_CH];
  cone_cube_t cube_r [NUM_CH];
  cone_cube_t rnd [NUM_CH];
  cone_q24_t  q24_nxt [NUM_CH];
  cone_q24_t  q24_r [NUM_CH];

  // Stage three: square times value.
  always_comb begin
    for (int i = 0; i < NUM_CH; i++) begin
      cube_nxt[i] = CONE_CUBE_W'(cone_sq[i]) * CONE_CUBE_W'(cone_q16[i]);
    end
  end

  // Stage four: round to nearest in Q.24.
  always_comb begin
    for (int i = 0; i < NUM_CH; i++) begin
      rnd[i]     = cube_r[i] + CONE_CUBE_W'(1 << 23);
      q24_nxt[i] = rnd[i][CONE_Q24_W+23:24];
    end
  end

  // Valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v3_r <= in_valid;
      v4_r <= v3_r;
    end
  end

  // Data registers.
  always_ff @(posedge clk) begin
    cube_r <= cube_nxt;
    q24_r  <= q24_nxt;
  end

  assign out_valid = v4_r;
  assign cone_q24  = q24_r;

endmodule

// ----- src/olrgb_mix.sv -----
// Second matrix, rounding to Q.14 and the gamut test, with the output registers.
// Two register stages. Depends on olrgb_pkg.
`timescale 1ns / 1ps

module olrgb_mix
  import olrgb_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  cone_q24_t cone_q24 [NUM_CH],
  output logic      out_valid,
  output chan_t     chan [NUM_CH],
  output logic      out_of_gamut
);

  logic      v5_r;
  logic      v6_r;
  prod_t     prod_nxt [NUM_CH][NUM_CH];
  prod_t     prod_r [NUM_CH][NUM_CH];
  chan_sum_t sum [NUM_CH];
  logic      bad_ch [NUM_CH];
  logic      bad_nxt;
  logic      bad_r;
  chan_t     chan_nxt [NUM_CH];
  chan_t     chan_r [NUM_CH];

  // Stage five: the nine products of the second matrix.
  always_comb begin
    for (int i = 0; i < NUM_CH; i++) begin
      for (int j = 0; j < NUM_CH; j++) begin
        prod_nxt[i][j] = PROD_W'($signed({1'b0, cone_q24[j]})) * PROD_W'(RGB_COEF[i][j]);
      end
    end
  end

  // Stage six: sum with rounding bias, range test, zero all channels when out of gamut.
  always_comb begin
    bad_nxt = 1'b0;
    for (int i = 0; i < NUM_CH; i++) begin
      sum[i] = CHAN_SUM_W'(prod_r[i][0]) + CHAN_SUM_W'(prod_r[i][1])
             + CHAN_SUM_W'(prod_r[i][2]) + CHAN_SUM_W'(1 << 23);
      bad_ch[i] = sum[i][CHAN_SUM_W-1]
               || (sum[i][CHAN_SUM_W-2:24] > (CHAN_SUM_W-25)'(ONE_Q14));
      bad_nxt = bad_nxt | bad_ch[i];
    end
    for (int i = 0; i < NUM_CH; i++) begin
      chan_nxt[i] = bad_nxt ? '0 : sum[i][OUT_W+23:24];
    end
  end

  // Valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else begin
      v5_r <= in_valid;
      v6_r <= v5_r;
    end
  end

  // Data registers.
  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    chan_r <= chan_nxt;
    bad_r  <= bad_nxt;
  end

  assign out_valid    = v6_r;
  assign chan         = chan_r;
  assign out_of_gamut = bad_r;

endmodule

// ----- src/oklab_to_linear_rgb_unit.sv -----
// Top level of the OKLab to linear RGB converter.
// Instantiates olrgb_cone, olrgb_cube and olrgb_mix; depends on olrgb_pkg.
`timescale 1ns / 1ps

// Converts one OKLab pixel in signed Q1.14 to linear red, green and blue in unsigned
// Q1.14 every clock cycle in which busy is low. A word is taken at each rising edge with
// start high and busy low; busy is high only during reset and for the cycle after it. The
// pipeline has six register stages (first matrix, clamp and square, cube, cube rounding,
// second matrix products, sums and gamut test), and each result appears on the out_ ports
// once its word has passed all six, marked by a one-cycle out_valid strobe. The receiver
// cannot stall the unit and must take every result in the cycle it is shown. When any
// channel falls below zero or above 1.0, all three channels read zero and
// out_out_of_gamut is set.
module oklab_to_linear_rgb_unit
  import olrgb_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic signed [15:0]   in_lightness,
  input  logic signed [15:0]   in_green_red,
  input  logic signed [15:0]   in_blue_yellow,
  output logic                 out_valid,
  output logic [14:0]          out_red,
  output logic [14:0]          out_green,
  output logic [14:0]          out_blue,
  output logic                 out_out_of_gamut
);

  logic      busy_r;
  logic      accept;
  logic      cone_valid;
  cone_q16_t cone_q16 [NUM_CH];
  cone_sq_t  cone_sq [NUM_CH];
  logic      cube_valid;
  cone_q24_t cone_q24 [NUM_CH];
  chan_t     chan [NUM_CH];

  // Hold off new words while in reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy   = busy_r;
  assign accept = start & ~busy_r;

  olrgb_cone u_cone (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (accept),
    .lab_l     (in_lightness),
    .lab_a     (in_green_red),
    .lab_b     (in_blue_yellow),
    .out_valid (cone_valid),
    .cone_q16  (cone_q16),
    .cone_sq   (cone_sq)
  );

  olrgb_cube u_cube (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (cone_valid),
    .cone_q16  (cone_q16),
    .cone_sq   (cone_sq),
    .out_valid (cube_valid),
    .cone_q24  (cone_q24)
  );

  olrgb_mix u_mix (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (cube_valid),
    .cone_q24     (cone_q24),
    .out_valid    (out_valid),
    .chan         (chan),
    .out_of_gamut (out_out_of_gamut)
  );

  assign out_red   = chan[0];
  assign out_green = chan[1];
  assign out_blue  = chan[2];

endmodule

// ----- src/olrgb_checker.sv -----
// Port-level checks for the OKLab to linear RGB unit, bound to the top level.
// Depends on olrgb_pkg and oklab_to_linear_rgb_unit_defines.svh.
`timescale 1ns / 1ps
`include "oklab_to_linear_rgb_unit_defines.svh"

module olrgb_checker
  import olrgb_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input logic [14:0] out_red,
  input logic [14:0] out_green,
  input logic [14:0] out_blue,
  input logic        out_out_of_gamut
);

  logic all_zero;
  logic all_in_range;

  // Channel summaries used by the range checks below.
  assign all_zero     = (out_red == 15'd0) && (out_green == 15'd0) && (out_blue == 15'd0);
  assign all_in_range = (out_red <= 15'(ONE_Q14)) && (out_green <= 15'(ONE_Q14))
                     && (out_blue <= 15'(ONE_Q14));

  // Every word taken yields one result after the fixed pipeline depth, and no other.
  `OLRGB_ASSERT_ALWAYS(a_latency, out_valid == $past(start && !busy, LATENCY))

  // An out-of-gamut result carries zero on every channel.
  `OLRGB_ASSERT_IMP(a_gamut_zero, out_valid && out_out_of_gamut, all_zero)

  // An in-gamut result never exceeds 1.0 on any channel.
  `OLRGB_ASSERT_IMP(a_in_range, out_valid && !out_out_of_gamut, all_in_range)

  // Whenever rst_n was high at the previous edge, busy is low, so the unit takes every word offered.
  `OLRGB_ASSERT_IMP(a_never_busy, $past(rst_n), !busy)

endmodule

bind oklab_to_linear_rgb_unit olrgb_checker u_olrgb_checker (.*);

// ----- tb/sv/tb.sv -----
// Self-checking testbench for oklab_to_linear_rgb_unit: directed corner pixels, then random
// pixels under three sender idle patterns, each result checked against a fixed-point predictor.
// Depends on olrgb_pkg and the RTL of the converter.
`timescale 1ns / 1ps

module tb;
  import olrgb_pkg::*;

  // One converted pixel as it leaves the unit.
  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
    logic  gamut_flag;
  } rgb_word_t;

  localparam int STALL_LIMIT  = 2000;
  localparam int REPORT_LIMIT = 10;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  lab_t in_lightness = '0;
  lab_t in_green_red = '0;
  lab_t in_blue_yellow = '0;
  logic out_valid;
  chan_t out_red;
  chan_t out_green;
  chan_t out_blue;
  logic out_out_of_gamut;

  rgb_word_t expected_rgb_q [$];
  int mismatch_count = 0;
  int stall_cycles = 0;

  oklab_to_linear_rgb_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_lightness     (in_lightness),
    .in_green_red     (in_green_red),
    .in_blue_yellow   (in_blue_yellow),
    .out_valid        (out_valid),
    .out_red          (out_red),
    .out_green        (out_green),
    .out_blue         (out_blue),
    .out_out_of_gamut (out_out_of_gamut)
  );

  // 2 ns clock.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Cone value for one matrix row: clamp at zero, round Q.30 to Q.16, cube, round to Q.24.
  function automatic longint cube_cone(input longint sum_q30);
    longint c;
    longint cube;
    if (sum_q30 <= 0) return 0;
    c = (sum_q30 + 64'sd8192) >>> 14;
    cube = c * c * c;
    return (cube + (64'sd1 <<< 23)) >>> 24;
  endfunction

  // Expected linear RGB for one OKLab pixel.
  function automatic rgb_word_t predict_linear_rgb(input lab_t lum, input lab_t ga, input lab_t by);
    longint l_cube;
    longint m_cube;
    longint s_cube;
    longint mix [3];
    longint chan [3];
    logic out_of_range;
    rgb_word_t res;
    l_cube = cube_cone(longint'(lum) * 65536 + longint'(ga) * 25974 + longint'(by) * 14143);
    m_cube = cube_cone(longint'(lum) * 65536 - longint'(ga) * 6918 - longint'(by) * 4185);
    s_cube = cube_cone(longint'(lum) * 65536 - longint'(ga) * 5864 - longint'(by) * 84639);
    mix[0] = l_cube * 64429 - m_cube * 52275 + s_cube * 3650;
    mix[1] = -l_cube * 20047 + m_cube * 42161 - s_cube * 5551;
    mix[2] = -l_cube * 66 - m_cube * 11527 + s_cube * 27978;
    out_of_range = 1'b0;
    // Round each channel to Q.14 and test it against the range 0 to 1.0.
    for (int i = 0; i < 3; i++) begin
      mix[i] = mix[i] + (64'sd1 <<< 23);
      if (mix[i] < 0) begin
        out_of_range = 1'b1;
        chan[i] = 0;
      end else begin
        chan[i] = mix[i] >>> 24;
        if (chan[i] > ONE_Q14) out_of_range = 1'b1;
      end
    end
    if (out_of_range) begin
      res = '0;
      res.gamut_flag = 1'b1;
    end else begin
      res.red = chan[0][OUT_W-1:0];
      res.green = chan[1][OUT_W-1:0];
      res.blue = chan[2][OUT_W-1:0];
      res.gamut_flag = 1'b0;
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what, input rgb_word_t want, input rgb_word_t got);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT)
      $display("%0t: %s: expected r=%0d g=%0d b=%0d oog=%0b, got r=%0d g=%0d b=%0d oog=%0b",
               $realtime, what, want.red, want.green, want.blue, want.gamut_flag,
               got.red, got.green, got.blue, got.gamut_flag);
  endtask

  // Predict each accepted word, then check each result against the oldest prediction.
  always @(posedge clk) begin : rgb_scoreboard
    rgb_word_t want;
    rgb_word_t got;
    if (rst_n && start && !busy)
      expected_rgb_q.push_back(predict_linear_rgb(in_lightness, in_green_red, in_blue_yellow));
    if (rst_n && out_valid) begin
      got = '{out_red, out_green, out_blue, out_out_of_gamut};
      if (expected_rgb_q.size() == 0) begin
        report_mismatch("result with no pixel pending", '0, got);
      end else begin
        want = expected_rgb_q.pop_front();
        if (want.red != got.red || want.green != got.green || want.blue != got.blue ||
            want.gamut_flag != got.gamut_flag)
          report_mismatch("pixel mismatch", want, got);
      end
    end
  end

  // Watchdog: ends the run after too many cycles in which no word moves.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // Send one pixel word after a random idle stretch, and return once it is taken.
  // Start stays high on return so that back-to-back words need no gap.
  task automatic send_pixel(input lab_t lum, input lab_t ga, input lab_t by, input int idle_pct);
    int gap;
    gap = 0;
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_lightness <= lum;
    in_green_red <= ga;
    in_blue_yellow <= by;
    do @(posedge clk); while (busy);
  endtask

  // Field extremes, black, white, clamped cones and pixels on both sides of the gamut.
  task automatic test_corner_pixels();
    send_pixel(16'sd0, 16'sd0, 16'sd0, 0);
    send_pixel(16'sd16384, 16'sd0, 16'sd0, 0);
    send_pixel(16'sd16400, 16'sd0, 16'sd0, 0);
    send_pixel(16'sd8192, 16'sd0, 16'sd0, 0);
    send_pixel(16'sd1, 16'sd0, 16'sd0, 0);
    send_pixel(-16'sd1, 16'sd0, 16'sd0, 0);
    send_pixel(-16'sd32768, -16'sd32768, -16'sd32768, 0);
    send_pixel(16'sd32767, 16'sd32767, 16'sd32767, 0);
    send_pixel(16'sd32767, -16'sd32768, 16'sd32767, 0);
    send_pixel(-16'sd32768, 16'sd32767, -16'sd32768, 0);
    send_pixel(16'sd16384, -16'sd32768, -16'sd32768, 0);
    send_pixel(16'sd0, 16'sd32767, 16'sd0, 0);
    send_pixel(16'sd0, -16'sd32768, 16'sd0, 0);
    send_pixel(16'sd0, 16'sd0, 16'sd32767, 0);
    send_pixel(16'sd0, 16'sd0, -16'sd32768, 0);
    send_pixel(16'sd10240, 16'sd3000, 16'sd0, 0);
    send_pixel(16'sd10240, -16'sd3000, 16'sd0, 0);
    send_pixel(16'sd10240, 16'sd0, 16'sd3000, 0);
    send_pixel(16'sd10240, 16'sd0, -16'sd3000, 0);
    send_pixel(16'sd8192, -16'sd2000, 16'sd1500, 0);
    send_pixel(16'sd12000, 16'sd500, -16'sd400, 0);
    send_pixel(-16'sd16384, 16'sd1000, 16'sd1000, 0);
  endtask

  // Random pixels: mostly near or inside the gamut, the rest any 16-bit pattern.
  task automatic test_random_pixels(input int count, input int idle_pct);
    lab_t lum;
    lab_t ga;
    lab_t by;
    int pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 60) begin
        lum = lab_t'($urandom_range(16384));
        ga = lab_t'(int'($urandom_range(12000)) - 6000);
        by = lab_t'(int'($urandom_range(12000)) - 6000);
      end else if (pick < 75) begin
        lum = lab_t'(int'($urandom_range(17000)) - 300);
        ga = lab_t'(int'($urandom_range(800)) - 400);
        by = lab_t'(int'($urandom_range(800)) - 400);
      end else begin
        lum = lab_t'($urandom);
        ga = lab_t'($urandom);
        by = lab_t'($urandom);
      end
      send_pixel(lum, ga, by, idle_pct);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_corner_pixels();
    test_random_pixels(480, 35);
    test_random_pixels(450, 80);
    test_random_pixels(500, 0);
    start <= 1'b0;

    // Drain the pipeline, then watch a little longer for stray results.
    while (expected_rgb_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);

    if (mismatch_count == 0 && expected_rgb_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      if (expected_rgb_q.size() != 0)
        $display("%0d pixels never produced a result", expected_rgb_q.size());
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
